FILE: design/bpfl_pkg.sv
`default_nettype none

package bpfl_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_ITEMS_PER_BLOCK = 256;
  localparam int DEF_MAX_BLOCKS      = 8;

  // Fixed field widths
  localparam int ADDR_W   = 23;
  localparam int SIZE_W   = 13;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int OUTST_W  = 12;
  localparam int BLKCNT_W = 4;

  // Slot size limits and reset value
  localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd16;
  localparam logic [SIZE_W-1:0] SIZE_MIN   = 13'd1;
  localparam logic [SIZE_W-1:0] SIZE_MAX   = 13'd4096;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK          = 2'd0,
    STS_EXHAUSTED   = 2'd1,
    STS_NOT_IN_POOL = 2'd2,
    STS_BLOCK_FULL  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_POP,
    ST_FSCAN,
    ST_FIN
  } state_e;

endpackage

`default_nettype wire

FILE: design/block_pool_free_list_allocator.sv
`default_nettype none

// Fixed-size slot allocator. A request is taken when start is high and busy
// is low. Its single result appears on the result ports for one cycle with
// done_o high, in the cycle in which busy falls. The receiver cannot stall,
// so the result must be captured then. The free addresses of each block live
// in one stack memory. A block that is created or cleared is not swept but
// marked as holding its fill pattern. That pattern is computed by a
// multiplier when such an entry is popped, so there is no clearing pass
// after reset. An allocate goes through block pick and memory read, fill
// product and result before it is idle again; when the pool is exhausted
// it skips the fill product. Clear and the unused command go straight to
// the result. Free scans the created blocks in order, starting at block
// zero, until one owns the address or all have been checked, then gives
// its result. The address-range scan checks one block per cycle.
// A new request may be given while the previous result is on the ports.
module block_pool_free_list_allocator
  import bpfl_pkg::*;
#(
  parameter int ITEMS_PER_BLOCK = DEF_ITEMS_PER_BLOCK,
  parameter int MAX_BLOCKS      = DEF_MAX_BLOCKS
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [SIZE_W-1:0]   cfg_wdata_i,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [CMD_W-1:0]    command_i,
  input  wire logic [ADDR_W-1:0]   address_i,
  output logic                     done_o,
  output logic      [ADDR_W-1:0]   address_out_o,
  output logic      [STATUS_W-1:0] status_o,
  output logic      [OUTST_W-1:0]  outstanding_o,
  output logic      [BLKCNT_W-1:0] blocks_in_use_o
);

  localparam int DEPTH = MAX_BLOCKS * ITEMS_PER_BLOCK;
  localparam int AW    = $clog2(DEPTH);
  localparam int BW    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW    = $clog2(MAX_BLOCKS + 1);
  localparam int TW    = $clog2(ITEMS_PER_BLOCK + 1);
  localparam int JW    = $clog2(ITEMS_PER_BLOCK);
  localparam int OW    = $clog2(DEPTH + 1);
  localparam int SW    = (AW + SIZE_W > ADDR_W) ? AW + SIZE_W : ADDR_W + 1;

  localparam logic [TW-1:0] TOP_FULL = TW'(ITEMS_PER_BLOCK);
  localparam logic [JW-1:0] J_LAST   = JW'(ITEMS_PER_BLOCK - 1);

  // Control and block table
  state_e            state_q, state_d;
  logic [SIZE_W-1:0] item_size_q;
  logic [TW-1:0]     top_q   [MAX_BLOCKS];
  logic [TW-1:0]     top_d   [MAX_BLOCKS];
  logic [TW-1:0]     mark_q  [MAX_BLOCKS];
  logic [TW-1:0]     mark_d  [MAX_BLOCKS];
  logic [SIZE_W-1:0] fsize_q [MAX_BLOCKS];
  logic [SIZE_W-1:0] fsize_d [MAX_BLOCKS];
  logic [CW-1:0]     count_q, count_d;
  logic [OW-1:0]     outst_q, outst_d;
  logic              done_q, done_d;

  // Request payload and working registers
  cmd_e              cmd_q, cmd_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  status_e           sts_q, sts_d;
  logic              has_addr_q, has_addr_d;
  logic              use_mem_q, use_mem_d;
  logic [AW-1:0]     pidx_q, pidx_d;
  logic [SIZE_W-1:0] psize_q, psize_d;
  logic [CW-1:0]     b_q, b_d;
  logic [SW-1:0]     base_q, base_d;
  logic [SW-1:0]     span_q, span_d;

  // Result registers
  logic [ADDR_W-1:0]   res_addr_q, res_addr_d;
  logic [STATUS_W-1:0] res_sts_q, res_sts_d;
  logic [OUTST_W-1:0]  res_outst_q, res_outst_d;
  logic [BLKCNT_W-1:0] res_blk_q, res_blk_d;

  // Datapath nets
  logic [SIZE_W-1:0] sz;
  logic              found;
  logic [BW-1:0]     alloc_sel;
  logic              can_create;
  logic [BW-1:0]     alloc_blk;
  logic [BW-1:0]     blk;
  logic [TW-1:0]     top_sel;
  logic [TW-1:0]     mark_sel;
  logic [SIZE_W-1:0] fsize_sel;
  logic [JW-1:0]     pop_j;
  logic [SW-1:0]     addr_ext;
  logic              in_range;
  logic              scan_end;
  logic              mem_we;
  logic              mem_re;
  logic [AW-1:0]     mem_waddr;
  logic [AW-1:0]     mem_raddr;
  logic [ADDR_W-1:0] mem_rdata;
  logic [ADDR_W-1:0] fill_addr;

  // Clamp the slot size to its legal range
  always_comb begin
    priority if (item_size_q == '0) begin
      sz = SIZE_MIN;
    end else if (item_size_q > SIZE_MAX) begin
      sz = SIZE_MAX;
    end else begin
      sz = item_size_q;
    end
  end

  // Find the first created block with a free slot
  always_comb begin
    found     = 1'b0;
    alloc_sel = '0;
    for (int b = MAX_BLOCKS - 1; b >= 0; b--) begin
      if ((CW'(b) < count_q) && (top_q[b] != '0)) begin
        found     = 1'b1;
        alloc_sel = BW'(b);
      end
    end
  end

  assign can_create = (count_q < CW'(MAX_BLOCKS));
  assign alloc_blk  = found ? alloc_sel : count_q[BW-1:0];
  assign blk        = (state_q == ST_FSCAN) ? b_q[BW-1:0] : alloc_blk;
  assign top_sel    = top_q[blk];
  assign mark_sel   = mark_q[blk];
  assign fsize_sel  = fsize_q[blk];
  assign pop_j      = found ? JW'(top_sel - TW'(1)) : J_LAST;

  // Range check of the freed address against the block under scan
  assign addr_ext = SW'(addr_q);
  assign scan_end = (b_q >= count_q);
  assign in_range = (addr_ext >= base_q) && (addr_ext < base_q + span_q);

  assign mem_raddr = AW'(alloc_blk) * AW'(ITEMS_PER_BLOCK) + AW'(pop_j);
  assign mem_waddr = AW'(blk) * AW'(ITEMS_PER_BLOCK) + AW'(top_sel[JW-1:0]);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          unique case (command_i)
            CMD_ALLOC: state_d = ST_ALLOC;
            CMD_FREE:  state_d = ST_FSCAN;
            default:   state_d = ST_FIN;
          endcase
        end
      end
      ST_ALLOC: state_d = (found || can_create) ? ST_POP : ST_FIN;
      ST_POP:   state_d = ST_FIN;
      ST_FSCAN: state_d = (scan_end || in_range) ? ST_FIN : ST_FSCAN;
      ST_FIN:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Block table updates, memory access and result capture
  always_comb begin
    top_d       = top_q;
    mark_d      = mark_q;
    fsize_d     = fsize_q;
    count_d     = count_q;
    outst_d     = outst_q;
    done_d      = 1'b0;
    cmd_d       = cmd_q;
    addr_d      = addr_q;
    sts_d       = sts_q;
    has_addr_d  = has_addr_q;
    use_mem_d   = use_mem_q;
    pidx_d      = pidx_q;
    psize_d     = psize_q;
    b_d         = b_q;
    base_d      = base_q;
    span_d      = span_q;
    res_addr_d  = res_addr_q;
    res_sts_d   = res_sts_q;
    res_outst_d = res_outst_q;
    res_blk_d   = res_blk_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_d      = cmd_e'(command_i);
          addr_d     = address_i;
          sts_d      = STS_OK;
          has_addr_d = 1'b0;
          b_d        = '0;
          base_d     = '0;
          span_d     = SW'(ITEMS_PER_BLOCK) * SW'(sz);
          // Clear: mark every created block as freshly filled
          if (cmd_e'(command_i) == CMD_CLEAR) begin
            for (int b = 0; b < MAX_BLOCKS; b++) begin
              if (CW'(b) < count_q) begin
                top_d[b]   = TOP_FULL;
                mark_d[b]  = TOP_FULL;
                fsize_d[b] = sz;
              end
            end
            outst_d = '0;
          end
        end
      end

      ST_ALLOC: begin
        if (found || can_create) begin
          mem_re     = 1'b1;
          has_addr_d = 1'b1;
          use_mem_d  = found && (TW'(pop_j) >= mark_sel);
          pidx_d     = AW'(alloc_blk) * AW'(ITEMS_PER_BLOCK)
                       + AW'(ITEMS_PER_BLOCK - 1) - AW'(pop_j);
          psize_d    = found ? fsize_sel : sz;
          outst_d    = outst_q + OW'(1);
          if (found) begin
            top_d[alloc_blk] = top_sel - TW'(1);
          end else begin
            // Create the next block and pop its slot 0
            top_d[alloc_blk]   = TW'(ITEMS_PER_BLOCK - 1);
            mark_d[alloc_blk]  = TOP_FULL;
            fsize_d[alloc_blk] = sz;
            count_d            = count_q + CW'(1);
          end
        end else begin
          sts_d = STS_EXHAUSTED;
        end
      end

      ST_POP: begin
        // Memory data and fill product settle in this cycle
      end

      ST_FSCAN: begin
        priority if (scan_end) begin
          sts_d = STS_NOT_IN_POOL;
        end else if (in_range) begin
          if (top_sel == TOP_FULL) begin
            sts_d = STS_BLOCK_FULL;
          end else begin
            // Push; entries at or above the mark now come from memory
            mem_we       = 1'b1;
            top_d[blk]   = top_sel + TW'(1);
            outst_d      = outst_q - OW'(1);
            if (top_sel < mark_sel) begin
              mark_d[blk] = top_sel;
            end
          end
        end else begin
          b_d    = b_q + CW'(1);
          base_d = base_q + span_q;
        end
      end

      ST_FIN: begin
        done_d      = 1'b1;
        res_addr_d  = has_addr_q ? (use_mem_q ? mem_rdata : fill_addr) : '0;
        res_sts_d   = sts_q;
        res_outst_d = OUTST_W'(outst_q);
        res_blk_d   = BLKCNT_W'(count_q);
      end

      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      item_size_q <= SIZE_RESET;
      count_q     <= CW'(1);
      outst_q     <= '0;
      done_q      <= 1'b0;
      for (int b = 0; b < MAX_BLOCKS; b++) begin
        top_q[b]   <= (b == 0) ? TOP_FULL : '0;
        mark_q[b]  <= TOP_FULL;
        fsize_q[b] <= (b == 0) ? SIZE_RESET : '0;
      end
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      outst_q <= outst_d;
      done_q  <= done_d;
      top_q   <= top_d;
      mark_q  <= mark_d;
      fsize_q <= fsize_d;
      if (cfg_we_i) begin
        item_size_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    addr_q      <= addr_d;
    sts_q       <= sts_d;
    has_addr_q  <= has_addr_d;
    use_mem_q   <= use_mem_d;
    pidx_q      <= pidx_d;
    psize_q     <= psize_d;
    b_q         <= b_d;
    base_q      <= base_d;
    span_q      <= span_d;
    res_addr_q  <= res_addr_d;
    res_sts_q   <= res_sts_d;
    res_outst_q <= res_outst_d;
    res_blk_q   <= res_blk_d;
  end

  // Free-address stacks; a push and a later pop of the same entry never fall
  // in the same cycle, so no forwarding is needed
  bpfl_stack_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_stack_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (addr_q),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Fill pattern of an entry not pushed since its block was filled
  bpfl_fill_gen #(
    .AW (AW)
  ) u_fill_gen (
    .clk_i      (clk_i),
    .en_i       (state_q == ST_POP),
    .slot_idx_i (pidx_q),
    .size_i     (psize_q),
    .addr_o     (fill_addr)
  );

  assign busy            = (state_q != ST_IDLE);
  assign done_o          = done_q;
  assign address_out_o   = res_addr_q;
  assign status_o        = res_sts_q;
  assign outstanding_o   = res_outst_q;
  assign blocks_in_use_o = res_blk_q;

endmodule

`default_nettype wire

FILE: design/bpfl_stack_mem.sv
`default_nettype none

module bpfl_stack_mem
  import bpfl_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_BLOCKS * DEF_ITEMS_PER_BLOCK,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AW-1:0]     waddr_i,
  input  wire logic [ADDR_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [AW-1:0]     raddr_i,
  output logic      [ADDR_W-1:0] rdata_o
);

  logic [ADDR_W-1:0] mem_q [DEPTH];

  // Write one pushed address
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: design/bpfl_fill_gen.sv
`default_nettype none

module bpfl_fill_gen
  import bpfl_pkg::*;
#(
  parameter int AW = $clog2(DEF_MAX_BLOCKS * DEF_ITEMS_PER_BLOCK)
) (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic [AW-1:0]     slot_idx_i,
  input  wire logic [SIZE_W-1:0] size_i,
  output logic      [ADDR_W-1:0] addr_o
);

  localparam int PW = AW + SIZE_W;
  localparam int MW = (PW > ADDR_W) ? PW : ADDR_W;

  logic [MW-1:0] prod;

  // Slot byte offset of an untouched fill entry, wrapped to the address width
  assign prod = MW'(slot_idx_i) * MW'(size_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      addr_o <= prod[ADDR_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: design/bpfl_checker.sv
`default_nettype none

module bpfl_checker
  import bpfl_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                done_o,
  input wire logic [ADDR_W-1:0]   address_out_o,
  input wire logic [STATUS_W-1:0] status_o
);

  // An accepted request makes the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("request accepted but block not busy");

  // Every request ends with its result strobe
  a_fall_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result");

  // A result is only shown once the request has retired
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  // Strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held");

  // A failed request hands out no address
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != STATUS_W'(STS_OK)) |-> (address_out_o == '0))
    else $error("address given with an error status");

endmodule

bind block_pool_free_list_allocator bpfl_checker u_bpfl_checker (.*);

`default_nettype wire

FILE: verif/testbench.sv
`default_nettype none

module testbench;
  import bpfl_pkg::*;

  localparam int ITEMS  = DEF_ITEMS_PER_BLOCK;
  localparam int BLOCKS = DEF_MAX_BLOCKS;
  localparam int TOTAL  = ITEMS * BLOCKS;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [ADDR_W-1:0]   addr;
    status_e             sts;
    logic [OUTST_W-1:0]  outst;
    logic [BLKCNT_W-1:0] blocks;
  } reply_t;

  // Free-list state of the pool and the replies still owed by the block
  class slot_ledger;
    logic [ADDR_W-1:0] slot_stack [TOTAL];
    int unsigned       fill_level [BLOCKS];
    int unsigned       blocks_made;
    logic [SIZE_W-1:0] size_reg;
    reply_t            due_replies [$];
    int unsigned       errors;

    function new();
      size_reg = SIZE_RESET;
      foreach (slot_stack[i]) slot_stack[i] = '0;
      foreach (fill_level[i]) fill_level[i] = 0;
      blocks_made = 1;
      errors = 0;
      refill(0);
    endfunction

    function void set_size(logic [SIZE_W-1:0] v);
      size_reg = v;
    endfunction

    // Clamp the slot size into 1..4096
    function longint slot_bytes();
      if (size_reg == 0) return 1;
      if (size_reg > 4096) return 4096;
      return longint'(size_reg);
    endfunction

    // Refill one block so that its slot 0 is on top
    function void refill(int unsigned b);
      longint sz;
      longint base;
      longint a;
      sz = slot_bytes();
      base = longint'(b) * ITEMS * sz;
      for (int j = 0; j < ITEMS; j++) begin
        a = base + longint'(ITEMS - 1 - j) * sz;
        slot_stack[b * ITEMS + j] = a[ADDR_W-1:0];
      end
      fill_level[b] = ITEMS;
    endfunction

    function logic [ADDR_W-1:0] pop(int unsigned b);
      fill_level[b]--;
      return slot_stack[b * ITEMS + fill_level[b]];
    endfunction

    function int pending();
      return due_replies.size();
    endfunction

    // Apply one accepted request and queue the reply it owes
    function reply_t book_request(logic [CMD_W-1:0] op, logic [ADDR_W-1:0] addr);
      reply_t      res;
      bit          hit;
      longint      span;
      longint      base;
      longint      a;
      int unsigned used;
      res.addr = '0;
      res.sts  = STS_OK;
      hit = 1'b0;
      a = longint'(addr);
      case (op)
        CMD_ALLOC: begin
          for (int b = 0; b < blocks_made && !hit; b++) begin
            if (fill_level[b] > 0) begin
              res.addr = pop(b);
              hit = 1'b1;
            end
          end
          if (!hit) begin
            if (blocks_made < BLOCKS) begin
              refill(blocks_made);
              blocks_made++;
              res.addr = pop(blocks_made - 1);
            end else begin
              res.sts = STS_EXHAUSTED;
            end
          end
        end
        CMD_FREE: begin
          span = longint'(ITEMS) * slot_bytes();
          for (int b = 0; b < blocks_made && !hit; b++) begin
            base = longint'(b) * span;
            if (a >= base && a < base + span) begin
              hit = 1'b1;
              if (fill_level[b] >= ITEMS) begin
                res.sts = STS_BLOCK_FULL;
              end else begin
                slot_stack[b * ITEMS + fill_level[b]] = addr;
                fill_level[b]++;
              end
            end
          end
          if (!hit) res.sts = STS_NOT_IN_POOL;
        end
        CMD_CLEAR: begin
          for (int b = 0; b < blocks_made; b++) refill(b);
        end
        default: ;
      endcase
      used = 0;
      for (int b = 0; b < blocks_made; b++) used += ITEMS - fill_level[b];
      res.outst  = used[OUTST_W-1:0];
      res.blocks = blocks_made[BLKCNT_W-1:0];
      due_replies.push_back(res);
      return res;
    endfunction

    // Compare one reply from the block with the oldest owed reply
    function void match_reply(logic [ADDR_W-1:0] a, logic [STATUS_W-1:0] s,
                              logic [OUTST_W-1:0] o, logic [BLKCNT_W-1:0] n);
      reply_t want;
      if (due_replies.size() == 0) begin
        $error("reply with no request outstanding");
        errors++;
        return;
      end
      want = due_replies.pop_front();
      if (a !== want.addr) begin
        $error("address_out: expected %0d, got %0d", want.addr, a);
        errors++;
      end
      if (s !== want.sts) begin
        $error("status: expected %0d, got %0d", want.sts, s);
        errors++;
      end
      if (o !== want.outst) begin
        $error("outstanding: expected %0d, got %0d", want.outst, o);
        errors++;
      end
      if (n !== want.blocks) begin
        $error("blocks_in_use: expected %0d, got %0d", want.blocks, n);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [SIZE_W-1:0]   cfg_wdata_i = '0;
  logic                start = 1'b0;
  logic                busy;
  logic [CMD_W-1:0]    command_i = '0;
  logic [ADDR_W-1:0]   address_i = '0;
  logic                done_o;
  logic [ADDR_W-1:0]   address_out_o;
  logic [STATUS_W-1:0] status_o;
  logic [OUTST_W-1:0]  outstanding_o;
  logic [BLKCNT_W-1:0] blocks_in_use_o;

  slot_ledger        ledger;
  logic [ADDR_W-1:0] held_slots [$];
  int                burst_left = 0;
  int                cycle_count = 0;

  block_pool_free_list_allocator DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .address_i      (address_i),
    .done_o         (done_o),
    .address_out_o  (address_out_o),
    .status_o       (status_o),
    .outstanding_o  (outstanding_o),
    .blocks_in_use_o(blocks_in_use_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Capture every reply strobe
  always @(posedge clk_i) begin
    if (rst_ni && done_o === 1'b1)
      ledger.match_reply(address_out_o, status_o, outstanding_o, blocks_in_use_o);
  end

  // Give up on a hung block
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("testbench: FAIL");
    $finish;
  end

  // Present one request in the current burst, open a gap when the burst is spent
  task automatic issue(input logic [CMD_W-1:0] op, input logic [ADDR_W-1:0] addr);
    reply_t res;
    int     gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      repeat (gap) begin
        @(negedge clk_i);
        start <= 1'b0;
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 10);
    end
    burst_left--;
    @(negedge clk_i);
    start     <= 1'b1;
    command_i <= op;
    address_i <= addr;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    res = ledger.book_request(op, addr);
    // Track slots handed out so that later frees are mostly legal
    if (op == CMD_ALLOC && res.sts == STS_OK) held_slots.push_back(res.addr);
    if (op == CMD_CLEAR) held_slots.delete();
  endtask

  // Drop start and let every owed reply come back
  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
    burst_left = 0;
  endtask

  // Write the slot size while idle, then clear the pool
  task automatic write_size(input logic [SIZE_W-1:0] v);
    drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    ledger.set_size(v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    issue(CMD_CLEAR, ADDR_W'($urandom_range(0, 23'h7FFFFF)));
  endtask

  // Mostly legal traffic on held slots, with stray and repeated frees mixed in
  task automatic run_random(input int count, input int alloc_pct);
    int                r;
    int                idx;
    longint            reach;
    logic [ADDR_W-1:0] a;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < alloc_pct) begin
        issue(CMD_ALLOC, ADDR_W'($urandom_range(0, 23'h7FFFFF)));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60 && held_slots.size() > 0) begin
          idx = $urandom_range(0, held_slots.size() - 1);
          a = held_slots[idx];
          held_slots.delete(idx);
          issue(CMD_FREE, a);
        end else if (r < 70 && held_slots.size() > 0) begin
          issue(CMD_FREE, held_slots[$urandom_range(0, held_slots.size() - 1)]);
        end else if (r < 80) begin
          issue(CMD_FREE, ADDR_W'($urandom_range(0, 23'h7FFFFF)));
        end else if (r < 90) begin
          reach = longint'(ledger.blocks_made + 1) * ITEMS * ledger.slot_bytes();
          if (reach > 64'h7FFFFF) reach = 64'h7FFFFF;
          issue(CMD_FREE, ADDR_W'($urandom_range(0, int'(reach))));
        end else if (r < 96) begin
          issue(CMD_UNUSED, ADDR_W'($urandom_range(0, 23'h7FFFFF)));
        end else begin
          issue(CMD_CLEAR, ADDR_W'($urandom_range(0, 23'h7FFFFF)));
        end
      end
    end
  endtask

  initial begin
    ledger = new();
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Unused command, frees that miss or hit a full block, repeated and odd frees
    issue(CMD_UNUSED, 23'h7FFFFF);
    issue(CMD_FREE, 23'd0);
    issue(CMD_FREE, 23'h7FFFFF);
    issue(CMD_FREE, 23'd4096);
    issue(CMD_ALLOC, 23'd0);
    issue(CMD_ALLOC, 23'h7FFFFF);
    issue(CMD_FREE, 23'd16);
    issue(CMD_FREE, 23'd16);
    issue(CMD_FREE, 23'd5);
    issue(CMD_ALLOC, 23'd0);
    issue(CMD_FREE, 23'd5);
    issue(CMD_ALLOC, 23'd0);
    issue(CMD_CLEAR, 23'd0);

    // Slot size of zero behaves as one byte
    write_size(13'd0);
    issue(CMD_ALLOC, 23'd0);
    issue(CMD_FREE, 23'd255);
    issue(CMD_FREE, 23'd256);

    // Oversized slot size clamps to the maximum
    write_size(13'h1FFF);
    issue(CMD_ALLOC, 23'd0);
    issue(CMD_ALLOC, 23'd0);
    issue(CMD_FREE, 23'd4096);
    issue(CMD_FREE, 23'd1048575);
    issue(CMD_FREE, 23'd1048576);

    // Random traffic over a spread of slot sizes
    write_size(13'd1);
    run_random(40, 50);
    write_size(13'($urandom_range(2, 4095)));
    run_random(40, 65);
    write_size(13'd7);
    run_random(40, 45);
    write_size(13'd4096);
    run_random(40, 55);
    write_size(SIZE_RESET);
    run_random(40, 50);

    // Run block zero dry at the largest slot size so that block one is created
    write_size(13'd4096);
    repeat (ITEMS + 4) begin
      issue(CMD_ALLOC, ADDR_W'($urandom_range(0, 23'h7FFFFF)));
    end
    issue(CMD_ALLOC, 23'h7FFFFF);
    issue(CMD_FREE, 23'h7FF000);
    issue(CMD_FREE, 23'h7FFFFF);
    run_random(20, 35);

    drain();
    if (ledger.errors == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
